### rtl/aclt_pkg.sv
// aclt_pkg: shared types and constants for the ap client mac learning table
// no dependencies; used by all rtl files of the block by scoped reference
package aclt_pkg;

    localparam int MAC_W     = 48;
    localparam int COUNT_W   = 32;
    localparam int APIDX_W   = 4;
    localparam int SLOT_W    = 6;
    localparam int FOUND_W   = 7;
    localparam int LEN_W     = 16;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0]     MIN_FRAME_LEN      = 16'd27;
    localparam logic [COUNT_W-1:0]   COUNT_MAX          = 32'hFFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AP_COUNT       = 1'b1;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_LOAD_AP = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AP,
        S_CREQ,
        S_CCMP,
        S_CUPD,
        S_RREQ,
        S_RDAT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MAC_W-1:0]   addr;
        logic [COUNT_W-1:0] count;
        logic [APIDX_W-1:0] ap;
    } t_client;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### rtl/aclt_ap_table.sv
// aclt_ap_table: access point address registers with resettable select bits
// depends on aclt_pkg
module aclt_ap_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_wr_idx,
    input  logic [aclt_pkg::MAC_W-1:0] i_wr_addr,
    input  logic                     i_wr_sel,
    input  logic [AW-1:0]            i_rd_idx,
    output logic [aclt_pkg::MAC_W-1:0] o_rd_addr,
    output logic                     o_rd_sel
);

    logic [aclt_pkg::MAC_W-1:0] r_addr [DEPTH];
    logic [DEPTH-1:0]           r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (i_we) begin
            r_sel[i_wr_idx] <= i_wr_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_addr[i_wr_idx] <= i_wr_addr;
        end
    end

    assign o_rd_addr = r_addr[i_rd_idx];
    assign o_rd_sel  = r_sel[i_rd_idx];

endmodule

### rtl/aclt_client_mem.sv
// aclt_client_mem: single-port client table ram with registered read
// depends on aclt_pkg
module aclt_client_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               i_clk,
    input  aclt_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  aclt_pkg::t_client  i_wr_data,
    output aclt_pkg::t_client  o_rd_data
);

    aclt_pkg::t_client r_mem [DEPTH];
    aclt_pkg::t_client r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

### rtl/ap_client_mac_learning_table.sv
// ap_client_mac_learning_table: top level, sequencer and shared 48-bit comparator
// depends on aclt_pkg, aclt_ap_table, aclt_client_mem
// sequence: load, clear and ignored frames go to the result directly; a read fetches the slot if it is valid,
//   a frame sweeps the ap entries and compares client entries per matching ap entry; output stalls hold the result
// throughput: one item at a time; set by the single-port client ram and one comparator
// reset: synchronous; clears control, config, select bits and client count, not the rams
module ap_client_mac_learning_table #(
    parameter int AP_SLOTS     = 16,
    parameter int CLIENT_SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aclt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [aclt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [aclt_pkg::LEN_W-1:0]          i_frame_len,
    input  logic [aclt_pkg::MAC_W-1:0]          i_src_mac,
    input  logic [aclt_pkg::MAC_W-1:0]          i_dst_mac,
    input  logic [3:0]                          i_ap_slot,
    input  logic [aclt_pkg::MAC_W-1:0]          i_ap_address,
    input  logic                                i_ap_chosen,
    input  logic [aclt_pkg::SLOT_W-1:0]         i_client_slot_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_matched,
    output logic                                o_new_client,
    output logic                                o_table_full,
    output logic [aclt_pkg::SLOT_W-1:0]         o_client_slot,
    output logic [aclt_pkg::MAC_W-1:0]          o_client_address,
    output logic [aclt_pkg::COUNT_W-1:0]        o_frame_count,
    output logic [aclt_pkg::APIDX_W-1:0]        o_client_ap,
    output logic [aclt_pkg::FOUND_W-1:0]        o_clients_found
);

    localparam int AIW = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;
    localparam int AIC = $clog2(AP_SLOTS + 1);
    localparam int CIW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int CIC = $clog2(CLIENT_SLOTS + 1);

    aclt_pkg::t_state r_state, n_state;

    logic                          r_cap;
    logic [aclt_pkg::CFG_W-1:0]    r_ap_count;
    logic [CIC-1:0]                r_total, n_total;
    logic                          r_o_valid, n_o_valid;

    logic [aclt_pkg::MAC_W-1:0]    r_src, n_src;
    logic [aclt_pkg::MAC_W-1:0]    r_dst, n_dst;
    logic [aclt_pkg::SLOT_W-1:0]   r_cslot, n_cslot;
    logic [AIC-1:0]                r_i, n_i;
    logic [CIC-1:0]                r_j, n_j;

    logic                          r_w_matched, n_w_matched;
    logic                          r_w_new, n_w_new;
    logic                          r_w_full, n_w_full;
    logic [aclt_pkg::SLOT_W-1:0]   r_w_slot, n_w_slot;
    logic [aclt_pkg::MAC_W-1:0]    r_w_addr, n_w_addr;
    logic [aclt_pkg::COUNT_W-1:0]  r_w_count, n_w_count;
    logic [aclt_pkg::APIDX_W-1:0]  r_w_ap, n_w_ap;

    logic                          r_o_matched, n_o_matched;
    logic                          r_o_new, n_o_new;
    logic                          r_o_full, n_o_full;
    logic [aclt_pkg::SLOT_W-1:0]   r_o_slot, n_o_slot;
    logic [aclt_pkg::MAC_W-1:0]    r_o_addr, n_o_addr;
    logic [aclt_pkg::COUNT_W-1:0]  r_o_count, n_o_count;
    logic [aclt_pkg::APIDX_W-1:0]  r_o_ap, n_o_ap;
    logic [aclt_pkg::FOUND_W-1:0]  r_o_found, n_o_found;

    logic                          ap_we;
    logic [AIW-1:0]                ap_wr_idx;
    logic [aclt_pkg::MAC_W-1:0]    ap_rd_addr;
    logic                          ap_rd_sel;
    aclt_pkg::t_mem_ctl            mem_ctl;
    logic [CIW-1:0]                mem_addr;
    aclt_pkg::t_client             mem_wr_data;
    aclt_pkg::t_client             mem_rd_data;

    logic [aclt_pkg::MAC_W-1:0]    cmp_a, cmp_b;
    logic                          cmp_eq;
    logic [31:0]                   ap_limit;
    logic                          ap_end;
    logic                          ap_hit;
    logic                          j_in_table;
    logic                          room;
    logic                          cslot_valid;
    logic                          frame_take;
    logic                          out_load;
    logic [aclt_pkg::COUNT_W-1:0]  count_inc;

    aclt_ap_table #(
        .DEPTH (AP_SLOTS),
        .AW    (AIW)
    ) u_ap_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (ap_we),
        .i_wr_idx  (ap_wr_idx),
        .i_wr_addr (i_ap_address),
        .i_wr_sel  (i_ap_chosen),
        .i_rd_idx  (r_i[AIW-1:0]),
        .o_rd_addr (ap_rd_addr),
        .o_rd_sel  (ap_rd_sel)
    );

    aclt_client_mem #(
        .DEPTH (CLIENT_SLOTS),
        .AW    (CIW)
    ) u_client_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    // shared compare unit: ap address vs source, or client address vs destination
    assign cmp_a  = (r_state == aclt_pkg::S_CCMP) ? mem_rd_data.addr : ap_rd_addr;
    assign cmp_b  = (r_state == aclt_pkg::S_CCMP) ? r_dst : r_src;
    assign cmp_eq = (cmp_a == cmp_b);

    assign ap_limit    = (32'(r_ap_count) > 32'(AP_SLOTS)) ? 32'(AP_SLOTS) : 32'(r_ap_count);
    assign ap_end      = (32'(r_i) >= ap_limit);
    assign ap_hit      = ap_rd_sel && cmp_eq;
    assign j_in_table  = (r_j < r_total);
    assign room        = (32'(r_total) < 32'(CLIENT_SLOTS));
    assign cslot_valid = (32'(r_cslot) < 32'(r_total));
    assign frame_take  = r_cap && (i_frame_len > aclt_pkg::MIN_FRAME_LEN);
    assign out_load    = !r_o_valid || i_ready;
    assign count_inc   = (mem_rd_data.count == aclt_pkg::COUNT_MAX) ?
                         mem_rd_data.count : mem_rd_data.count + 1'b1;
    assign ap_wr_idx   = AIW'(i_ap_slot);

    always_comb begin
        n_state = r_state;
        case (r_state)
            aclt_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (aclt_pkg::t_op'(i_op))
                        aclt_pkg::OP_FRAME: n_state = frame_take ? aclt_pkg::S_AP
                                                                 : aclt_pkg::S_DONE;
                        aclt_pkg::OP_READ:  n_state = aclt_pkg::S_RREQ;
                        default:            n_state = aclt_pkg::S_DONE;
                    endcase
                end
            end
            aclt_pkg::S_AP: begin
                if (ap_end) begin
                    n_state = aclt_pkg::S_DONE;
                end else if (ap_hit) begin
                    n_state = aclt_pkg::S_CREQ;
                end
            end
            aclt_pkg::S_CREQ: n_state = j_in_table ? aclt_pkg::S_CCMP : aclt_pkg::S_AP;
            aclt_pkg::S_CCMP: n_state = cmp_eq ? aclt_pkg::S_CUPD : aclt_pkg::S_CREQ;
            aclt_pkg::S_CUPD: n_state = aclt_pkg::S_AP;
            aclt_pkg::S_RREQ: n_state = cslot_valid ? aclt_pkg::S_RDAT : aclt_pkg::S_DONE;
            aclt_pkg::S_RDAT: n_state = aclt_pkg::S_DONE;
            aclt_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = aclt_pkg::S_IDLE;
                end
            end
            default: n_state = aclt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_total     = r_total;
        n_src       = r_src;
        n_dst       = r_dst;
        n_cslot     = r_cslot;
        n_i         = r_i;
        n_j         = r_j;
        n_w_matched = r_w_matched;
        n_w_new     = r_w_new;
        n_w_full    = r_w_full;
        n_w_slot    = r_w_slot;
        n_w_addr    = r_w_addr;
        n_w_count   = r_w_count;
        n_w_ap      = r_w_ap;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_matched = r_o_matched;
        n_o_new     = r_o_new;
        n_o_full    = r_o_full;
        n_o_slot    = r_o_slot;
        n_o_addr    = r_o_addr;
        n_o_count   = r_o_count;
        n_o_ap      = r_o_ap;
        n_o_found   = r_o_found;
        ap_we       = 1'b0;
        mem_ctl     = '0;
        mem_addr    = CIW'(r_j);
        mem_wr_data = '0;
        case (r_state)
            aclt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_src       = i_src_mac;
                    n_dst       = i_dst_mac;
                    n_cslot     = i_client_slot_in;
                    n_i         = '0;
                    n_j         = '0;
                    n_w_matched = 1'b0;
                    n_w_new     = 1'b0;
                    n_w_full    = 1'b0;
                    n_w_slot    = '0;
                    n_w_addr    = '0;
                    n_w_count   = '0;
                    n_w_ap      = '0;
                    if (aclt_pkg::t_op'(i_op) == aclt_pkg::OP_LOAD_AP &&
                        32'(i_ap_slot) < 32'(AP_SLOTS)) begin
                        ap_we = 1'b1;
                    end
                    if (aclt_pkg::t_op'(i_op) == aclt_pkg::OP_CLEAR) begin
                        n_total = '0;
                    end
                end
            end
            aclt_pkg::S_AP: begin
                if (!ap_end) begin
                    if (ap_hit) begin
                        n_w_matched = 1'b1;
                        n_j         = '0;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            aclt_pkg::S_CREQ: begin
                if (j_in_table) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = CIW'(r_j);
                end else begin
                    n_i = r_i + 1'b1;
                    if (room) begin
                        mem_ctl.wr_en     = 1'b1;
                        mem_addr          = CIW'(r_total);
                        mem_wr_data.addr  = r_dst;
                        mem_wr_data.count = aclt_pkg::COUNT_W'(1);
                        mem_wr_data.ap    = aclt_pkg::APIDX_W'(r_i);
                        n_w_new           = 1'b1;
                        n_w_slot          = aclt_pkg::SLOT_W'(r_total);
                        n_w_addr          = r_dst;
                        n_w_count         = aclt_pkg::COUNT_W'(1);
                        n_w_ap            = aclt_pkg::APIDX_W'(r_i);
                        n_total           = r_total + 1'b1;
                    end else begin
                        n_w_full = 1'b1;
                    end
                end
            end
            aclt_pkg::S_CCMP: begin
                if (!cmp_eq) begin
                    n_j = r_j + 1'b1;
                end
            end
            aclt_pkg::S_CUPD: begin
                mem_ctl.wr_en     = 1'b1;
                mem_addr          = CIW'(r_j);
                mem_wr_data.addr  = mem_rd_data.addr;
                mem_wr_data.count = count_inc;
                mem_wr_data.ap    = mem_rd_data.ap;
                n_w_slot          = aclt_pkg::SLOT_W'(r_j);
                n_w_addr          = mem_rd_data.addr;
                n_w_count         = count_inc;
                n_w_ap            = mem_rd_data.ap;
                n_i               = r_i + 1'b1;
            end
            aclt_pkg::S_RREQ: begin
                n_w_slot = r_cslot;
                if (cslot_valid) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = CIW'(r_cslot);
                end
            end
            aclt_pkg::S_RDAT: begin
                n_w_addr  = mem_rd_data.addr;
                n_w_count = mem_rd_data.count;
                n_w_ap    = mem_rd_data.ap;
            end
            aclt_pkg::S_DONE: begin
                if (out_load) begin
                    n_o_valid   = 1'b1;
                    n_o_matched = r_w_matched;
                    n_o_new     = r_w_new;
                    n_o_full    = r_w_full;
                    n_o_slot    = r_w_slot;
                    n_o_addr    = r_w_addr;
                    n_o_count   = r_w_count;
                    n_o_ap      = r_w_ap;
                    n_o_found   = aclt_pkg::FOUND_W'(r_total);
                end
            end
            default: begin
                n_o_valid = r_o_valid && !i_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aclt_pkg::S_IDLE;
            r_cap      <= 1'b0;
            r_ap_count <= '0;
            r_total    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aclt_pkg::CFG_CAPTURE_ENABLE: r_cap      <= i_cfg_data[0];
                    aclt_pkg::CFG_AP_COUNT:       r_ap_count <= i_cfg_data;
                    default:                      r_cap      <= r_cap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_cslot     <= n_cslot;
        r_i         <= n_i;
        r_j         <= n_j;
        r_w_matched <= n_w_matched;
        r_w_new     <= n_w_new;
        r_w_full    <= n_w_full;
        r_w_slot    <= n_w_slot;
        r_w_addr    <= n_w_addr;
        r_w_count   <= n_w_count;
        r_w_ap      <= n_w_ap;
        r_o_matched <= n_o_matched;
        r_o_new     <= n_o_new;
        r_o_full    <= n_o_full;
        r_o_slot    <= n_o_slot;
        r_o_addr    <= n_o_addr;
        r_o_count   <= n_o_count;
        r_o_ap      <= n_o_ap;
        r_o_found   <= n_o_found;
    end

    assign o_ready          = (r_state == aclt_pkg::S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_matched        = r_o_matched;
    assign o_new_client     = r_o_new;
    assign o_table_full     = r_o_full;
    assign o_client_slot    = r_o_slot;
    assign o_client_address = r_o_addr;
    assign o_frame_count    = r_o_count;
    assign o_client_ap      = r_o_ap;
    assign o_clients_found  = r_o_found;

endmodule
